// ----- src/mbd_pkg.sv -----
// package for the multi-button debouncer: event and configuration types,
// register indexes, reset values and queue sizing. no dependencies.
`timescale 1ns / 1ps

package mbd_pkg;

  // fixed field widths
  localparam int CODE_W   = 8;
  localparam int BIDX_W   = 3;
  localparam int PIN_W    = 5;
  localparam int TIME_W   = 32;
  localparam int MS_W     = 16;
  localparam int BCNT_W   = 4;
  localparam int PMAP_W   = 40;
  localparam int TABLE_W  = 64;
  localparam int SAMPLE_W = 32;
  localparam int CIDX_W   = 3;
  localparam int CDATA_W  = 64;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_BUTTON_COUNT  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_PIN_MAP       = 3'd1;
  localparam logic [CIDX_W-1:0] REG_PRESS_EVENTS  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_LONG_EVENTS   = 3'd3;
  localparam logic [CIDX_W-1:0] REG_DEBOUNCE_MS   = 3'd4;
  localparam logic [CIDX_W-1:0] REG_LONG_PRESS_MS = 3'd5;

  // reset values of the timing registers
  localparam logic [MS_W-1:0] DEBOUNCE_RESET   = 16'd20;
  localparam logic [MS_W-1:0] LONG_PRESS_RESET = 16'd600;

  // event queue between scan and output stage
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [BIDX_W-1:0] button;
    logic              is_long;
    logic              last;
  } event_t;

  typedef struct packed {
    logic [BCNT_W-1:0]  button_count;
    logic [PMAP_W-1:0]  pin_map;
    logic [TABLE_W-1:0] press_events;
    logic [TABLE_W-1:0] long_events;
    logic [MS_W-1:0]    debounce_ms;
    logic [MS_W-1:0]    long_press_ms;
  } cfg_t;

endpackage

// ----- src/mbd_front.sv -----
// front part: takes gpio samples, filters bus glitches and scans the buttons
// one per cycle unless a new event meets a full queue, updating per-button state and pushing events. uses mbd_pkg.
`timescale 1ns / 1ps

module mbd_front #(
  parameter int MAX_BUTTONS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mbd_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mbd_pkg::SAMPLE_W-1:0]  in_gpio_sample,
  input  logic [mbd_pkg::TIME_W-1:0]    in_now_ms,
  output logic                          push,
  output mbd_pkg::event_t               push_ev,
  input  logic                          q_full
);

  localparam int IDX_W = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
  localparam int CNT_W = $clog2(MAX_BUTTONS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]                     state_r, state_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic [mbd_pkg::SAMPLE_W-1:0]   bits_r, bits_nxt;
  logic [mbd_pkg::TIME_W-1:0]     now_r, now_nxt;
  logic                           held_r [MAX_BUTTONS];
  logic                           held_nxt [MAX_BUTTONS];
  logic                           ldone_r [MAX_BUTTONS];
  logic                           ldone_nxt [MAX_BUTTONS];
  logic [mbd_pkg::TIME_W-1:0]     ctime_r [MAX_BUTTONS];
  logic [mbd_pkg::TIME_W-1:0]     ctime_nxt [MAX_BUTTONS];
  logic                           pend_valid_r, pend_valid_nxt;
  mbd_pkg::event_t                pend_r, pend_nxt;

  logic [mbd_pkg::BCNT_W-1:0]     cnt_sat;
  logic [CNT_W-1:0]               n_act;
  logic [mbd_pkg::SAMPLE_W-1:0]   mask;
  logic [IDX_W-1:0]               idx;
  logic [mbd_pkg::PIN_W-1:0]      pin;
  logic                           pressed;
  logic [mbd_pkg::CODE_W-1:0]     long_code;
  logic [mbd_pkg::CODE_W-1:0]     press_code;
  logic                           has_long;
  logic [mbd_pkg::TIME_W-1:0]     elapsed;
  logic                           settled;
  logic                           emit;
  logic                           emit_long;
  logic                           upd_change;
  logic                           upd_long;
  logic                           step_ok;
  logic [CNT_W-1:0]               cnt_inc;

  // active button count and mask of the pins in use
  always_comb begin
    cnt_sat = (cfg.button_count > mbd_pkg::BCNT_W'(MAX_BUTTONS)) ?
              mbd_pkg::BCNT_W'(MAX_BUTTONS) : cfg.button_count;
    n_act   = CNT_W'(cnt_sat);
    mask    = '0;
    for (int j = 0; j < MAX_BUTTONS; j++) begin
      if (j < int'(n_act)) begin
        mask[cfg.pin_map[mbd_pkg::PIN_W*j +: mbd_pkg::PIN_W]] = 1'b1;
      end
    end
  end

  // decision for the button under scan
  always_comb begin
    idx        = cnt_r[IDX_W-1:0];
    pin        = cfg.pin_map[mbd_pkg::PIN_W*int'(idx) +: mbd_pkg::PIN_W];
    pressed    = ~bits_r[pin];
    long_code  = cfg.long_events[mbd_pkg::CODE_W*int'(idx) +: mbd_pkg::CODE_W];
    press_code = cfg.press_events[mbd_pkg::CODE_W*int'(idx) +: mbd_pkg::CODE_W];
    has_long   = (long_code != '0);
    elapsed    = now_r - ctime_r[idx];
    settled    = (elapsed >= {16'd0, cfg.debounce_ms});
    upd_change = 1'b0;
    upd_long   = 1'b0;
    emit       = 1'b0;
    emit_long  = 1'b0;
    if (pressed != held_r[idx]) begin
      if (settled) begin
        upd_change = 1'b1;
        emit       = pressed ? !has_long : (has_long && !ldone_r[idx]);
      end
    end else if (pressed && has_long && !ldone_r[idx] &&
                 elapsed >= {16'd0, cfg.long_press_ms}) begin
      upd_long  = 1'b1;
      emit      = 1'b1;
      emit_long = 1'b1;
    end
    step_ok = !(emit && pend_valid_r && q_full);
    cnt_inc = cnt_r + 1'b1;
  end

  // sequencer: accept, scan, flush the held-back event
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    bits_nxt       = bits_r;
    now_nxt        = now_r;
    held_nxt       = held_r;
    ldone_nxt      = ldone_r;
    ctime_nxt      = ctime_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    push           = 1'b0;
    push_ev        = pend_r;
    in_stall       = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          bits_nxt = in_gpio_sample;
          now_nxt  = in_now_ms;
          cnt_nxt  = '0;
          if (n_act != '0 && (in_gpio_sample & mask) != '0) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (step_ok) begin
          if (upd_change) begin
            held_nxt[idx]  = pressed;
            ctime_nxt[idx] = now_r;
            if (pressed) begin
              ldone_nxt[idx] = 1'b0;
            end
          end
          if (upd_long) begin
            ldone_nxt[idx] = 1'b1;
          end
          if (emit) begin
            // the previous event is known not to be the last one
            if (pend_valid_r) begin
              push         = 1'b1;
              push_ev      = pend_r;
              push_ev.last = 1'b0;
            end
            pend_valid_nxt   = 1'b1;
            pend_nxt.code    = emit_long ? long_code : press_code;
            pend_nxt.button  = mbd_pkg::BIDX_W'(idx);
            pend_nxt.is_long = emit_long;
            pend_nxt.last    = 1'b0;
          end
          cnt_nxt = cnt_inc;
          if (cnt_inc == n_act) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (!q_full) begin
          push           = 1'b1;
          push_ev        = pend_r;
          push_ev.last   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and button state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      for (int k = 0; k < MAX_BUTTONS; k++) begin
        held_r[k]  <= 1'b0;
        ldone_r[k] <= 1'b0;
        ctime_r[k] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      held_r       <= held_nxt;
      ldone_r      <= ldone_nxt;
      ctime_r      <= ctime_nxt;
    end
  end

  // sample and held-back event payload
  always_ff @(posedge clk) begin
    bits_r <= bits_nxt;
    now_r  <= now_nxt;
    pend_r <= pend_nxt;
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("event pushed into a full queue");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (cnt_r < n_act))
    else $error("scan index beyond active buttons");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_valid_r)
    else $error("held-back event left over after a sample");

endmodule

// ----- src/mbd_queue.sv -----
// short event queue between the scan and the output stage.
// uses mbd_pkg for the event type and depth.
`timescale 1ns / 1ps

module mbd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mbd_pkg::event_t push_ev,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output mbd_pkg::event_t head
);

  mbd_pkg::event_t                 mem_r [mbd_pkg::QUEUE_DEPTH];
  logic [mbd_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [mbd_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [mbd_pkg::QCNT_W-1:0]      count_r, count_nxt;

  assign full      = (count_r == mbd_pkg::QCNT_W'(mbd_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  // pointer and fill level update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ev;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= mbd_pkg::QCNT_W'(mbd_pkg::QUEUE_DEPTH))
    else $error("queue fill level beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from an empty queue");

endmodule

// ----- src/mbd_back.sv -----
// back part: output register that drains the event queue onto the
// result channel. uses mbd_pkg for the event type.
`timescale 1ns / 1ps

module mbd_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_not_empty,
  input  mbd_pkg::event_t              q_head,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mbd_pkg::CODE_W-1:0]   out_event_code,
  output logic [mbd_pkg::BIDX_W-1:0]   out_button_index,
  output logic                         out_is_long,
  output logic                         out_last
);

  logic            valid_r, valid_nxt;
  mbd_pkg::event_t ev_r;

  // load a new beat when the register is empty or being taken
  assign pop = q_not_empty && (!valid_r || !out_stall);

  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ev_r <= q_head;
    end
  end

  assign out_valid        = valid_r;
  assign out_event_code   = ev_r.code;
  assign out_button_index = ev_r.button;
  assign out_is_long      = ev_r.is_long;
  assign out_last         = ev_r.last;

endmodule

// ----- src/multi_button_debounce_long_press_core.sv -----
// top level of the multi-button debouncer with long-press events.
// holds the configuration registers; uses mbd_pkg, mbd_front, mbd_queue, mbd_back.
//
//   channel   direction   beat contents
//   in_       input       gpio_sample (32), now_ms (32)
//   out_      output      event_code (8), button_index (3), is_long (1), last (1)
//   cfg_      input       we, index (3), wdata (64)
//
// a sample passes an accept state, then a scan of one button per cycle through the single
// state update path (held when a new event meets a full event queue), then a flush state;
// a sample skipped as a bus glitch or with no buttons in use leaves from the accept state.
// reset is synchronous: configuration returns to its defaults, buttons released.
// out_stall backs up the four-beat event queue, which then halts the button scan.
`timescale 1ns / 1ps

module multi_button_debounce_long_press_core #(
  parameter int MAX_BUTTONS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mbd_pkg::SAMPLE_W-1:0]  in_gpio_sample,
  input  logic [mbd_pkg::TIME_W-1:0]    in_now_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mbd_pkg::CODE_W-1:0]    out_event_code,
  output logic [mbd_pkg::BIDX_W-1:0]    out_button_index,
  output logic                          out_is_long,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic [mbd_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [mbd_pkg::CDATA_W-1:0]   cfg_wdata
);

  mbd_pkg::cfg_t   cfg_r, cfg_nxt;
  logic            push;
  mbd_pkg::event_t push_ev;
  logic            q_full;
  logic            q_not_empty;
  mbd_pkg::event_t q_head;
  logic            pop;

  // configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        mbd_pkg::REG_BUTTON_COUNT:  cfg_nxt.button_count  = cfg_wdata[mbd_pkg::BCNT_W-1:0];
        mbd_pkg::REG_PIN_MAP:       cfg_nxt.pin_map       = cfg_wdata[mbd_pkg::PMAP_W-1:0];
        mbd_pkg::REG_PRESS_EVENTS:  cfg_nxt.press_events  = cfg_wdata[mbd_pkg::TABLE_W-1:0];
        mbd_pkg::REG_LONG_EVENTS:   cfg_nxt.long_events   = cfg_wdata[mbd_pkg::TABLE_W-1:0];
        mbd_pkg::REG_DEBOUNCE_MS:   cfg_nxt.debounce_ms   = cfg_wdata[mbd_pkg::MS_W-1:0];
        mbd_pkg::REG_LONG_PRESS_MS: cfg_nxt.long_press_ms = cfg_wdata[mbd_pkg::MS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.button_count  <= '0;
      cfg_r.pin_map       <= '0;
      cfg_r.press_events  <= '0;
      cfg_r.long_events   <= '0;
      cfg_r.debounce_ms   <= mbd_pkg::DEBOUNCE_RESET;
      cfg_r.long_press_ms <= mbd_pkg::LONG_PRESS_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mbd_front #(
    .MAX_BUTTONS (MAX_BUTTONS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_gpio_sample (in_gpio_sample),
    .in_now_ms      (in_now_ms),
    .push           (push),
    .push_ev        (push_ev),
    .q_full         (q_full)
  );

  mbd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_ev   (push_ev),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  mbd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_head           (q_head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_code   (out_event_code),
    .out_button_index (out_button_index),
    .out_is_long      (out_is_long),
    .out_last         (out_last)
  );

endmodule
